>>> sv/tfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_pkg: shared types and constants of the trace format sniffer
// Result codes, varint phases, magic bytes and the config port layout.
// ----------------------------------------------------------------------------
package tfs_pkg;

	// result codes
	typedef enum logic [2:0] {
		KIND_UNKNOWN = 3'd0,
		KIND_ZIP     = 3'd1,
		KIND_GZIP    = 3'd2,
		KIND_JSON    = 3'd3,
		KIND_CTRACE  = 3'd4,
		KIND_SYMBOLS = 3'd5,
		KIND_PROTO   = 3'd6
	} kind_t;

	// varint walk over the leading protobuf fields, one-hot
	typedef enum logic [4:0] {
		VP_TAG     = 5'b00001,
		VP_LEN     = 5'b00010,
		VP_INNER   = 5'b00100,
		VP_MATCHED = 5'b01000,
		VP_FAILED  = 5'b10000
	} vphase_t;

	// control from the top level to the varint decoder
	typedef struct packed {
		logic take;   // a data byte is accepted this cycle
		logic clear;  // file ends this cycle, start over
	} vctrl_t;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_TAG  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_TAG = 1'b1;

	localparam logic [7:0]  PACKET_TAG_RST  = 8'd10;
	localparam logic [15:0] SYMBOLS_TAG_RST = 16'd490;

	// magic values, first byte in bits 7:0
	localparam logic [31:0] ZIP_MAGIC    = 32'h0403_4B50;
	localparam logic [15:0] GZIP_MAGIC   = 16'h8B1F;
	localparam logic [15:0] JSON_OBJ     = 16'h227B;
	localparam logic [23:0] JSON_ARR     = 24'h227B5B;
	localparam logic [7:0]  PROTO_LEAD   = 8'h0A;

	// compressed text marker: eight bytes held in the chain, newest in
	// cell 0, and the closing byte that arrives behind them
	localparam int MARK_CELLS = 8;
	localparam logic [7:0] MARK_HEAD [MARK_CELLS] = '{
		8'h78, 8'h0A, 8'h3A, 8'h45, 8'h43, 8'h41, 8'h52, 8'h54
	};
	localparam logic [7:0] MARK_TAIL = 8'h9C;

	// space, tab, newline, vertical tab, form feed, return
	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

endpackage
`default_nettype wire

>>> sv/tfs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_cell: one byte cell of the marker chain
// Holds one recent byte, hands it to the next cell on every data byte and
// flags a match against its own marker byte.
// ----------------------------------------------------------------------------
module tfs_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift_en,
	input  wire logic [7:0] byte_in,
	input  wire logic [7:0] match_byte,
	output logic      [7:0] byte_out,
	output logic            hit
);

	logic [7:0] data_q;

	// shift register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift_en) begin
			data_q <= byte_in;
		end
	end

	assign byte_out = data_q;
	assign hit      = (data_q == match_byte);

endmodule
`default_nettype wire

>>> sv/tfs_varint.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_varint: leading protobuf varint checker
// Gathers the first tag, the length and the inner tag one byte at a time and
// reports whether all three matched. Only the low 16 value bits are kept,
// plus a flag for any higher bit set.
// ----------------------------------------------------------------------------
module tfs_varint
	import tfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire vctrl_t      ctrl,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  packet_tag,
	input  wire logic [15:0] symbols_tag,
	output logic             matched_n
);

	vphase_t     phase_q, phase_n;
	logic [15:0] low_q, low_n, low_acc;
	logic        high_q, high_n, high_acc;
	logic [3:0]  count_q, count_n, count_inc;
	logic [6:0]  payload;
	logic        ok;
	logic        active;

	assign payload   = data_byte[6:0];
	assign count_inc = count_q + 4'd1;
	assign active    = (phase_q == VP_TAG) || (phase_q == VP_LEN) || (phase_q == VP_INNER);

	// fold the seven payload bits in at position 7*count
	always_comb begin
		low_acc  = low_q;
		high_acc = high_q;
		case (count_q)
			4'd0: low_acc = low_q | {9'd0, payload};
			4'd1: low_acc = low_q | {2'd0, payload, 7'd0};
			4'd2: begin
				low_acc  = low_q | {payload[1:0], 14'd0};
				high_acc = high_q | (|payload[6:2]);
			end
			4'd9:    high_acc = high_q | payload[0];
			default: high_acc = high_q | (|payload);
		endcase
	end

	// check of a finished varint against the current phase
	always_comb begin
		case (phase_q)
			VP_TAG:   ok = (low_acc == {8'd0, packet_tag}) && !high_acc;
			VP_LEN:   ok = (low_acc != 16'd0) || high_acc;
			VP_INNER: ok = (low_acc == symbols_tag) && !high_acc;
			default:  ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		low_n   = low_q;
		high_n  = high_q;
		count_n = count_q;
		if (ctrl.take && active) begin
			if (!data_byte[7]) begin
				case (phase_q)
					VP_TAG:   phase_n = ok ? VP_LEN : VP_FAILED;
					VP_LEN:   phase_n = ok ? VP_INNER : VP_FAILED;
					VP_INNER: phase_n = ok ? VP_MATCHED : VP_FAILED;
					default:  phase_n = VP_FAILED;
				endcase
				low_n   = '0;
				high_n  = 1'b0;
				count_n = '0;
			end else if (count_inc >= 4'd10) begin
				phase_n = VP_FAILED;
				low_n   = '0;
				high_n  = 1'b0;
				count_n = '0;
			end else begin
				low_n   = low_acc;
				high_n  = high_acc;
				count_n = count_inc;
			end
		end
	end

	assign matched_n = (phase_n == VP_MATCHED);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= VP_TAG;
			low_q   <= '0;
			high_q  <= 1'b0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			phase_q <= VP_TAG;
			low_q   <= '0;
			high_q  <= 1'b0;
			count_q <= '0;
		end else begin
			phase_q <= phase_n;
			low_q   <= low_n;
			high_q  <= high_n;
			count_q <= count_n;
		end
	end

endmodule
`default_nettype wire

>>> sv/trace_format_sniffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trace_format_sniffer: trace file format detector
// Streams a file one byte per transaction and reports its format code on
// the transaction marked last.
// ----------------------------------------------------------------------------
// The block takes one input transaction every cycle unless stalled: all
// per-byte work (magic and JSON prefix capture, an eight-cell byte chain
// matching the compressed text marker, a one-byte-per-cycle varint decoder)
// finishes in the cycle the byte is accepted. The format code is registered
// into a two-entry result buffer as the last transaction is accepted: into
// the output register, or into the skid entry while the output is stalled.
// Per-file state clears on that same edge, so the next file may start at
// once. Input stalls only when both entries are full. Config registers are
// written whenever cfg_we is high and should change only between files.
// ----------------------------------------------------------------------------
module trace_format_sniffer
	import tfs_pkg::*;
#(
	parameter int LOOKAHEAD = 64
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  byte_valid,
	input  wire logic                  last,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 trace_kind
);

	localparam int CNT_W = $clog2(LOOKAHEAD + 1);
	localparam logic [CNT_W-1:0] LA_MAX = CNT_W'(LOOKAHEAD);

	logic [7:0]       packet_tag_q;
	logic [15:0]      symbols_tag_q;

	logic             in_fire, take, res_fire, out_fire;
	logic [CNT_W-1:0] count_q, count_n;
	logic [31:0]      head_q, head_n;
	logic [1:0]       ns_count_q, ns_count_n;
	logic [23:0]      ns_prefix_q, ns_prefix_n;
	logic             marker_q, marker_n;
	logic             in_window, chain_hit;
	logic             matched_n;
	vctrl_t           vctrl;
	kind_t            kind;

	logic [7:0]       chain_byte [MARK_CELLS+1];
	logic [MARK_CELLS-1:0] cell_hit;

	logic             skid_valid_q;
	kind_t            skid_kind_q;
	logic             out_valid_q;
	kind_t            out_kind_q;

	// handshake
	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !in_stall;
	assign take     = in_fire && byte_valid;
	assign res_fire = in_fire && last;
	assign out_fire = out_valid_q && !out_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_tag_q  <= PACKET_TAG_RST;
			symbols_tag_q <= SYMBOLS_TAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PACKET_TAG:  packet_tag_q  <= cfg_data[7:0];
				REG_SYMBOLS_TAG: symbols_tag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// marker chain, newest byte in cell 0
	assign chain_byte[0] = data_byte;
	for (genvar i = 0; i < MARK_CELLS; i++) begin : g_cell
		tfs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (take),
			.byte_in    (chain_byte[i]),
			.match_byte (MARK_HEAD[i]),
			.byte_out   (chain_byte[i+1]),
			.hit        (cell_hit[i])
		);
	end
	assign chain_hit = &cell_hit;

	// varint decoder
	assign vctrl.take  = take;
	assign vctrl.clear = res_fire;

	tfs_varint u_varint (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (vctrl),
		.data_byte   (data_byte),
		.packet_tag  (packet_tag_q),
		.symbols_tag (symbols_tag_q),
		.matched_n   (matched_n)
	);

	// per-byte state update within the lookahead window
	assign in_window = (count_q < LA_MAX);

	always_comb begin
		count_n     = count_q;
		head_n      = head_q;
		ns_count_n  = ns_count_q;
		ns_prefix_n = ns_prefix_q;
		marker_n    = marker_q;
		if (take) begin
			if (count_q < CNT_W'(4)) begin
				case (count_q[1:0])
					2'd0:    head_n[7:0]   = data_byte;
					2'd1:    head_n[15:8]  = data_byte;
					2'd2:    head_n[23:16] = data_byte;
					default: head_n[31:24] = data_byte;
				endcase
			end
			if (in_window) begin
				if (!is_blank(data_byte) && (ns_count_q != 2'd3)) begin
					case (ns_count_q)
						2'd0:    ns_prefix_n[7:0]   = data_byte;
						2'd1:    ns_prefix_n[15:8]  = data_byte;
						default: ns_prefix_n[23:16] = data_byte;
					endcase
					ns_count_n = ns_count_q + 2'd1;
				end
				if ((count_q >= CNT_W'(8)) && chain_hit && (data_byte == MARK_TAIL)) begin
					marker_n = 1'b1;
				end
				count_n = count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			ns_count_q  <= '0;
			ns_prefix_q <= '0;
			marker_q    <= 1'b0;
		end else if (res_fire) begin
			count_q     <= '0;
			head_q      <= '0;
			ns_count_q  <= '0;
			ns_prefix_q <= '0;
			marker_q    <= 1'b0;
		end else begin
			count_q     <= count_n;
			head_q      <= head_n;
			ns_count_q  <= ns_count_n;
			ns_prefix_q <= ns_prefix_n;
			marker_q    <= marker_n;
		end
	end

	// classification in priority order
	always_comb begin
		if (count_n == '0) begin
			kind = KIND_UNKNOWN;
		end else if ((count_n >= CNT_W'(4)) && (head_n == ZIP_MAGIC)) begin
			kind = KIND_ZIP;
		end else if ((count_n >= CNT_W'(2)) && (head_n[15:0] == GZIP_MAGIC)) begin
			kind = KIND_GZIP;
		end else if ((ns_count_n >= 2'd2) && (ns_prefix_n[15:0] == JSON_OBJ)) begin
			kind = KIND_JSON;
		end else if ((ns_count_n == 2'd3) && (ns_prefix_n == JSON_ARR)) begin
			kind = KIND_JSON;
		end else if (marker_n) begin
			kind = KIND_CTRACE;
		end else if (matched_n) begin
			kind = KIND_SYMBOLS;
		end else if (head_n[7:0] == PROTO_LEAD) begin
			kind = KIND_PROTO;
		end else begin
			kind = KIND_UNKNOWN;
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_fire) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_fire;
			end
		end else if (res_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_fire) begin
			out_kind_q <= skid_valid_q ? skid_kind_q : kind;
		end else if (res_fire) begin
			skid_kind_q <= kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign trace_kind = out_kind_q;

endmodule
`default_nettype wire

>>> sv/tfs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_checker: port-level checks for the trace format sniffer
// Watches the top-level ports and flags illegal codes and buffer misuse.
// ----------------------------------------------------------------------------
module tfs_checker
	import tfs_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] trace_kind
);

	// a stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(trace_kind))
		else $error("result changed while stalled");

	// only defined format codes leave the block
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (trace_kind <= KIND_PROTO))
		else $error("undefined format code");

	// input stalls only behind a pending result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// stall starts only when the output was held back
	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall without output backpressure");

endmodule

bind trace_format_sniffer tfs_checker u_tfs_checker (.*);
`default_nettype wire

>>> tb/trace_kind_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trace_kind_checker: format code predictor and scoreboard
// Watches the config port and both channels of the sniffer, predicts the
// format code of every file from the accepted bytes and compares each
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module trace_kind_checker
	import tfs_pkg::*;
#(
	parameter int LOOKAHEAD = 64
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  byte_valid,
	input  wire logic                  last,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [2:0]            trace_kind,
	output int                         errors,
	output int                         pending
);

	// the eight bytes that must precede the closing marker byte, newest low
	localparam logic [63:0] MARK_RUN = 64'h5452_4143_453A_0A78;

	// register shadows
	logic [7:0]  packet_tag;
	logic [15:0] symbols_tag;

	// per-file state
	int unsigned taken;
	logic [31:0] head_word;
	int unsigned ns_count;
	logic [23:0] ns_bytes;
	logic [63:0] last_eight;
	logic        marker_seen;
	vphase_t     vphase;
	logic [63:0] vacc;
	int unsigned vlen;

	kind_t expected_kinds[$];

	function automatic logic blank_byte(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	task automatic restart_file();
		taken       = 0;
		head_word   = '0;
		ns_count    = 0;
		ns_bytes    = '0;
		last_eight  = '0;
		marker_seen = 1'b0;
		vphase      = VP_TAG;
		vacc        = '0;
		vlen        = 0;
	endtask

	// walk of the three leading varints: packet tag, length, inner tag
	task automatic feed_varint(input logic [7:0] b);
		logic ok;
		if (vphase != VP_MATCHED && vphase != VP_FAILED) begin
			// bits shifted past bit 63 fall away, so a tenth byte adds bit 0 only
			vacc = vacc | (64'(b[6:0]) << (7 * vlen));
			vlen++;
			if (!b[7]) begin
				case (vphase)
					VP_TAG:  ok = (vacc == 64'(packet_tag));
					VP_LEN:  ok = (vacc != 64'd0);
					default: ok = (vacc == 64'(symbols_tag));
				endcase
				if (!ok)
					vphase = VP_FAILED;
				else if (vphase == VP_TAG)
					vphase = VP_LEN;
				else if (vphase == VP_LEN)
					vphase = VP_INNER;
				else
					vphase = VP_MATCHED;
				vacc = '0;
				vlen = 0;
			end else if (vlen >= 10) begin
				vphase = VP_FAILED;
				vacc   = '0;
				vlen   = 0;
			end
		end
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		int unsigned pos;
		pos = taken;
		if (pos < 4)
			head_word[8*pos +: 8] = b;
		// prefix and marker only count inside the lookahead window
		if (pos < LOOKAHEAD) begin
			if (!blank_byte(b) && ns_count < 3) begin
				ns_bytes[8*ns_count +: 8] = b;
				ns_count++;
			end
			if (pos >= 8 && last_eight == MARK_RUN && b == MARK_TAIL)
				marker_seen = 1'b1;
			taken = pos + 1;
		end
		last_eight = {last_eight[55:0], b};
		feed_varint(b);
	endtask

	// priority order of the format checks
	function automatic kind_t predict_kind();
		if (taken == 0)
			return KIND_UNKNOWN;
		if (taken >= 4 && head_word == ZIP_MAGIC)
			return KIND_ZIP;
		if (taken >= 2 && head_word[15:0] == GZIP_MAGIC)
			return KIND_GZIP;
		if (ns_count >= 2 && ns_bytes[15:0] == JSON_OBJ)
			return KIND_JSON;
		if (ns_count >= 3 && ns_bytes == JSON_ARR)
			return KIND_JSON;
		if (marker_seen)
			return KIND_CTRACE;
		if (vphase == VP_MATCHED)
			return KIND_SYMBOLS;
		if (head_word[7:0] == PROTO_LEAD)
			return KIND_PROTO;
		return KIND_UNKNOWN;
	endfunction

	// compare results, track config, then predict from the accepted transaction
	always @(posedge clk or negedge arst_n) begin : watch
		kind_t want;
		if (!arst_n) begin
			packet_tag  = PACKET_TAG_RST;
			symbols_tag = SYMBOLS_TAG_RST;
			restart_file();
			expected_kinds.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_kinds.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual trace_kind %0d",
						$time, trace_kind);
					errors++;
				end else begin
					want = expected_kinds.pop_front();
					if (trace_kind !== want) begin
						$display("%0t: trace_kind mismatch, expected %0d, actual %0d",
							$time, want, trace_kind);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_PACKET_TAG)
					packet_tag = cfg_data[7:0];
				else if (cfg_index == REG_SYMBOLS_TAG)
					symbols_tag = cfg_data;
			end
			if (in_valid && !in_stall) begin
				if (byte_valid)
					absorb_byte(data_byte);
				if (last) begin
					expected_kinds.push_back(predict_kind());
					restart_file();
				end
			end
			pending = expected_kinds.size();
		end
	end

endmodule
`default_nettype wire

>>> tb/tb_trace_format_sniffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_trace_format_sniffer: testbench of the trace format sniffer
// Streams files of every format the sniffer knows, well-formed and broken,
// under several tag settings, with random idle cycles and stalls on both
// channels; a checker module beside the block predicts each format code.
// ----------------------------------------------------------------------------
module tb_trace_format_sniffer;
	import tfs_pkg::*;

	localparam int LOOKAHEAD     = 64;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS   = 135;

	localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	localparam logic [7:0] CTRACE_MARK [9] = '{
		8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h3A, 8'h0A, 8'h78, 8'h9C
	};

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_PACKET_TAG;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte  = '0;
	logic                  byte_valid = 1'b0;
	logic                  last       = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [2:0]            trace_kind;

	int fail_count;
	int results_due;
	int cycles     = 0;
	int items_sent = 0;

	// stimulus controls seen by the receiver
	logic no_idle  = 1'b0;
	logic hold_req = 1'b0;

	// tag values currently programmed, used to build matching files
	logic [7:0]  cur_packet_tag  = PACKET_TAG_RST;
	logic [15:0] cur_symbols_tag = SYMBOLS_TAG_RST;

	logic [7:0] file_q[$];

	trace_format_sniffer #(.LOOKAHEAD(LOOKAHEAD)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.trace_kind (trace_kind)
	);

	trace_kind_checker #(.LOOKAHEAD(LOOKAHEAD)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.trace_kind (trace_kind),
		.errors     (fail_count),
		.pending    (results_due)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run limit reached with %0d results outstanding", $time, results_due);
			$display("== FAIL ==");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, one long hold-off on request
	int   stall_left = 0;
	int   run_left   = 0;
	int   hold_left  = 0;
	logic hold_taken = 1'b0;

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			out_stall  <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (run_left > 0) begin
			run_left  <= run_left - 1;
			out_stall <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			run_left   <= $urandom_range(1, 10);
			out_stall  <= 1'b0;
		end
	end

	// one input transaction, with an optional idle gap ahead of it
	task automatic push_item(input logic [7:0] b, input logic bv, input logic lst);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		byte_valid <= bv;
		last       <= lst;
		do @(posedge clk); while (in_stall);
	endtask

	// send file_q, closed on its final byte or by a bare end transaction
	task automatic send_file(input logic bare_end);
		int n;
		n = file_q.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(8'($urandom), 1'b0, 1'b0);
				items_sent++;
			end
			push_item(file_q[i], 1'b1, !bare_end && (i == n - 1));
			items_sent++;
		end
		if (bare_end || n == 0) begin
			push_item(8'($urandom), 1'b0, 1'b1);
			items_sent++;
		end
	endtask

	// wait until every expected result is back and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_tags(input logic [15:0] pkt_data, input logic [15:0] sym_data);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PACKET_TAG;
		cfg_data  <= pkt_data;
		@(posedge clk);
		cfg_index <= REG_SYMBOLS_TAG;
		cfg_data  <= sym_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_packet_tag  = pkt_data[7:0];
		cur_symbols_tag = sym_data;
		@(posedge clk);
	endtask

	task automatic add_random(input int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(8'($urandom));
	endtask

	task automatic add_blanks(input int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(BLANKS[$urandom_range(0, 5)]);
	endtask

	// varint with pad redundant continuation groups after the minimal form
	task automatic add_varint(input logic [63:0] v, input int pad);
		int len;
		int total;
		len = 1;
		while (len < 10 && (v >> (7 * len)) != 64'd0)
			len++;
		total = len + pad;
		for (int i = 0; i < total; i++)
			file_q.push_back({i < total - 1, 7'(v >> (7 * i))});
	endtask

	function automatic int pick_pad();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(6, 10);
	endfunction

	task automatic build_random_file();
		int          shape;
		int          sel;
		int          k;
		logic [63:0] tag_v;
		logic [63:0] len_v;
		logic [63:0] sym_v;
		file_q.delete();
		shape = $urandom_range(0, 99);
		if (shape < 5) begin
			// empty file
		end else if (shape < 13) begin
			// zip magic, sometimes damaged or cut short
			file_q = '{8'h50, 8'h4B, 8'h03, 8'h04};
			if ($urandom_range(0, 3) == 0)
				file_q[$urandom_range(0, 3)] = 8'($urandom);
			if ($urandom_range(0, 5) == 0) begin
				k = $urandom_range(1, 3);
				while (file_q.size() > k)
					void'(file_q.pop_back());
			end else begin
				add_random($urandom_range(0, 6));
			end
		end else if (shape < 21) begin
			// gzip magic
			file_q = '{8'h1F, 8'h8B};
			if ($urandom_range(0, 3) == 0)
				file_q[$urandom_range(0, 1)] = 8'($urandom);
			add_random($urandom_range(0, 6));
		end else if (shape < 35) begin
			// json opening after whitespace, rarely past the window
			add_blanks(($urandom_range(0, 7) == 0) ? $urandom_range(58, 66)
				: $urandom_range(0, 4));
			sel = $urandom_range(0, 3);
			if (sel == 0) begin
				file_q.push_back(8'h7B);
				file_q.push_back(8'h22);
			end else if (sel == 1) begin
				file_q.push_back(8'h5B);
				file_q.push_back(8'h7B);
				file_q.push_back(8'h22);
			end else if (sel == 2) begin
				file_q.push_back(8'h5B);
				add_blanks($urandom_range(1, 3));
				file_q.push_back(8'h7B);
				add_blanks($urandom_range(0, 2));
				file_q.push_back(8'h22);
			end else begin
				file_q.push_back(($urandom_range(0, 1) == 0) ? 8'h7B : 8'h5B);
				file_q.push_back(8'($urandom));
			end
			add_random($urandom_range(0, 5));
		end else if (shape < 50) begin
			// compressed text marker, sometimes near the end of the window
			add_random(($urandom_range(0, 4) == 0) ? $urandom_range(44, 60)
				: $urandom_range(0, 8));
			k = file_q.size();
			for (int i = 0; i < 9; i++)
				file_q.push_back(CTRACE_MARK[i]);
			if ($urandom_range(0, 5) == 0)
				file_q[k + $urandom_range(0, 8)] = 8'($urandom);
			add_random($urandom_range(0, 3));
		end else if (shape < 80) begin
			// protobuf head: packet tag, length, inner tag
			sel   = $urandom_range(0, 9);
			tag_v = (sel == 0) ? 64'($urandom_range(0, 255)) : 64'(cur_packet_tag);
			len_v = (sel == 1) ? 64'd0 : 64'($urandom_range(1, 300));
			sym_v = (sel == 2) ? 64'($urandom_range(0, 65535)) : 64'(cur_symbols_tag);
			if ($urandom_range(0, 9) == 0) begin
				// ten-byte form: only bit 0 of the last group lands in the value
				for (int i = 0; i < 9; i++)
					file_q.push_back({1'b1, 7'(tag_v >> (7 * i))});
				file_q.push_back({1'b0, 6'($urandom), 1'($urandom)});
			end else begin
				add_varint(tag_v, pick_pad());
			end
			add_varint(len_v, pick_pad());
			add_varint(sym_v, pick_pad());
			add_random($urandom_range(0, 5));
			// truncated head
			if ($urandom_range(0, 6) == 0) begin
				k = $urandom_range(1, file_q.size() - 1);
				while (file_q.size() > k)
					void'(file_q.pop_back());
			end
		end else if (shape < 90) begin
			// leading protobuf byte with random rest
			file_q.push_back(PROTO_LEAD);
			add_random($urandom_range(0, 8));
		end else begin
			add_random($urandom_range(1, 12));
		end
	endtask

	task automatic run_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			build_random_file();
			send_file($urandom_range(0, 3) == 0);
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed files under reset tags: one per format
		file_q.delete();
		send_file(1'b1);
		file_q = '{8'h50, 8'h4B, 8'h03, 8'h04};
		send_file(1'b0);
		file_q = '{8'h1F, 8'h8B};
		send_file(1'b0);
		file_q = '{8'h7B, 8'h22};
		send_file(1'b1);
		file_q = '{8'h5B, 8'h7B, 8'h22};
		send_file(1'b0);
		file_q = '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h3A, 8'h0A, 8'h78, 8'h9C};
		send_file(1'b0);
		file_q = '{8'h0A, 8'h01, 8'hEA, 8'h03};
		send_file(1'b0);
		file_q = '{PROTO_LEAD};
		send_file(1'b0);
		settle();

		// low extremes of both tags
		set_tags(16'hFF00, 16'h0000);
		run_random(PHASE_ITEMS);
		settle();

		// high extremes, with a long output hold-off that fills the block
		set_tags(16'h00FF, 16'hFFFF);
		hold_req <= 1'b1;
		for (int i = 0; i < 16; i++) begin
			file_q = '{8'($urandom)};
			send_file(1'b0);
		end
		run_random(PHASE_ITEMS);
		settle();

		set_tags(16'($urandom), 16'($urandom));
		run_random(PHASE_ITEMS);
		settle();

		// back-to-back stretch with no idling on either side
		set_tags(16'($urandom), 16'($urandom));
		no_idle <= 1'b1;
		run_random(PHASE_ITEMS);
		settle();
		no_idle <= 1'b0;

		set_tags(16'(PACKET_TAG_RST), SYMBOLS_TAG_RST);
		run_random(PHASE_ITEMS);
		settle();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
